>>> design/tdpt_pkg.sv
// ----------------------------------------------------------------------------
// tdpt_pkg
// Shared command/status types for the trial division prime tester.
// ----------------------------------------------------------------------------
`default_nettype none
package tdpt_pkg;

    typedef struct packed {
        logic clr_start;   // start bitmap clear sweep
        logic siv_start;   // start sieve
        logic load;        // capture candidate
        logic tst_start;   // start trial division walk
    } tdpt_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic siv_done;
        logic tst_done;
    } tdpt_sts_t;

endpackage
`default_nettype wire

>>> design/tdpt_divider.sv
// ----------------------------------------------------------------------------
// tdpt_divider
// Restoring remainder unit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module tdpt_divider #(
    parameter int NW = 32,
    parameter int PW = 17
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [NW-1:0] dividend,
    input  wire logic [PW-1:0] divisor,
    output logic               done,
    output logic [PW-1:0]      remainder
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] quo_reg;
    logic [PW:0]   rem_reg;
    logic [PW-1:0] div_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic [PW:0]   trial;
    logic [PW:0]   diff;

    assign trial = {rem_reg[PW-1:0], quo_reg[NW-1]};
    assign diff  = trial - {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NW);
                done     <= 1'b0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                done    <= (cnt_reg == CW'(1));
                if (cnt_reg == CW'(1))
                    busy_reg <= 1'b0;
            end
            else
                done <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[NW-2:0], 1'b0};
            rem_reg <= diff[PW] ? trial : diff;
        end
    end

    assign remainder = rem_reg[PW-1:0];
endmodule
`default_nettype wire

>>> design/tdpt_datapath.sv
// ----------------------------------------------------------------------------
// tdpt_datapath
// Sieve bitmap, prime table and trial division walk.
// ----------------------------------------------------------------------------
`default_nettype none
module tdpt_datapath #(
    parameter int SIEVE_LIMIT  = 65536,
    parameter int TABLE_DEPTH  = 8192,
    parameter int NUMBER_WIDTH = 32
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire tdpt_pkg::tdpt_cmd_t    cmd,
    output tdpt_pkg::tdpt_sts_t         sts,
    input  wire logic [NUMBER_WIDTH-1:0] number_in,
    output logic [NUMBER_WIDTH-1:0]     number_out,
    output logic                        is_prime
);
    import tdpt_pkg::*;

    localparam int SW = $clog2(SIEVE_LIMIT);
    localparam int PW = SW + 1;
    localparam int TW = $clog2(TABLE_DEPTH);
    localparam int TC = TW + 1;
    localparam int NW = NUMBER_WIDTH;
    localparam int CMPW = (2*PW > NW) ? 2*PW : NW;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CLR   = 4'd1;
    localparam logic [3:0] S_RDI   = 4'd2;
    localparam logic [3:0] S_CHKI  = 4'd3;
    localparam logic [3:0] S_MARK  = 4'd4;
    localparam logic [3:0] S_COPY  = 4'd5;
    localparam logic [3:0] S_COPYW = 4'd6;
    localparam logic [3:0] S_TRD   = 4'd7;
    localparam logic [3:0] S_TSQ   = 4'd8;
    localparam logic [3:0] S_TCMP  = 4'd9;
    localparam logic [3:0] S_TDIV  = 4'd10;
    localparam logic [3:0] S_TREM  = 4'd11;
    localparam logic [3:0] S_TAB   = 4'd12;

    logic             bmp_mem [SIEVE_LIMIT];
    logic [PW-1:0]    tab_mem [TABLE_DEPTH];

    logic [3:0]       st_reg;
    logic [PW:0]      i_reg;
    logic [PW:0]      j_reg;
    logic [TC-1:0]    cnt_reg;
    logic [TC-1:0]    idx_reg;
    logic             bmp_rd_reg;
    logic [PW-1:0]    tab_rd_reg;
    logic [2*PW-1:0]  sq_reg;
    logic [NW-1:0]    n_reg;
    logic             prime_reg;
    logic             div_start;
    logic             div_done;
    logic [PW-1:0]    div_rem;
    logic             bmp_we;
    logic [SW-1:0]    bmp_wa;
    logic             bmp_wd;
    logic [SW-1:0]    bmp_ra;
    logic             clr_last;
    logic             copy_last;
    logic             tab_end;
    logic             sq_over;
    logic             div_hit;
    logic             small_n;
    tdpt_sts_t        sts_next;

    // one read port, one write port on the bitmap
    always_ff @(posedge clk)
    begin
        if (bmp_we)
            bmp_mem[bmp_wa] <= bmp_wd;
        bmp_rd_reg <= bmp_mem[bmp_ra];
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == S_COPYW && !bmp_rd_reg)
            tab_mem[cnt_reg[TW-1:0]] <= j_reg[PW-1:0];
        tab_rd_reg <= tab_mem[idx_reg[TW-1:0]];
    end

    always_comb
    begin
        bmp_we = 1'b0;
        bmp_wa = j_reg[SW-1:0];
        bmp_wd = 1'b1;
        bmp_ra = i_reg[SW-1:0];
        case (st_reg)
            S_CLR:
            begin
                bmp_we = 1'b1;
                bmp_wd = (j_reg < (PW+1)'(2));
            end
            S_MARK:  bmp_we = 1'b1;
            S_COPY:  bmp_ra = j_reg[SW-1:0];
            default: ;
        endcase
    end

    assign div_start = (st_reg == S_TDIV);

    tdpt_divider #(.NW(NW), .PW(PW)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (n_reg),
        .divisor   (tab_rd_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    assign clr_last  = (j_reg == (PW+1)'(SIEVE_LIMIT - 1));
    assign copy_last = clr_last || (!bmp_rd_reg && cnt_reg == TC'(TABLE_DEPTH - 1));
    assign tab_end   = (idx_reg >= cnt_reg);
    assign sq_over   = (CMPW'(sq_reg) > CMPW'(n_reg));
    // p*p <= n already implies quotient above 1
    assign div_hit   = div_done && (div_rem == '0);
    assign small_n   = !(n_reg > NW'(1));

    always_comb
    begin
        sts_next          = '0;
        sts_next.clr_done = (st_reg == S_CLR) && clr_last;
        sts_next.siv_done = (st_reg == S_COPYW) && copy_last;
        sts_next.tst_done = ((st_reg == S_IDLE) && !cmd.clr_start && !cmd.siv_start
                             && cmd.tst_start && small_n)
                            || ((st_reg == S_TRD) && tab_end)
                            || ((st_reg == S_TCMP) && sq_over)
                            || ((st_reg == S_TREM) && div_hit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sts <= '0;
        else
            sts <= sts_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= S_IDLE;
            cnt_reg   <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            idx_reg   <= '0;
            sq_reg    <= '0;
            prime_reg <= 1'b0;
        end
        else
        begin
            case (st_reg)
                S_IDLE:
                begin
                    if (cmd.clr_start)
                    begin
                        j_reg  <= '0;
                        st_reg <= S_CLR;
                    end
                    else if (cmd.siv_start)
                    begin
                        i_reg  <= (PW+1)'(2);
                        st_reg <= S_RDI;
                    end
                    else if (cmd.tst_start)
                    begin
                        idx_reg   <= '0;
                        prime_reg <= !small_n;
                        if (!small_n)
                            st_reg <= S_TRD;
                    end
                end
                S_CLR:
                begin
                    j_reg <= j_reg + 1'b1;
                    if (clr_last)
                        st_reg <= S_IDLE;
                end
                S_RDI:
                begin
                    sq_reg <= (2*PW)'(i_reg) * (2*PW)'(i_reg);
                    st_reg <= S_CHKI;
                end
                S_CHKI:
                begin
                    if (sq_reg >= (2*PW)'(SIEVE_LIMIT))
                    begin
                        j_reg   <= (PW+1)'(2);
                        cnt_reg <= '0;
                        st_reg  <= S_COPY;
                    end
                    else if (bmp_rd_reg)
                    begin
                        i_reg  <= i_reg + 1'b1;
                        st_reg <= S_RDI;
                    end
                    else
                    begin
                        j_reg  <= sq_reg[PW:0];
                        st_reg <= S_MARK;
                    end
                end
                S_MARK:
                begin
                    if (j_reg + i_reg >= (PW+1)'(SIEVE_LIMIT))
                    begin
                        i_reg  <= i_reg + 1'b1;
                        st_reg <= S_RDI;
                    end
                    j_reg <= j_reg + i_reg;
                end
                S_COPY:  st_reg <= S_COPYW;
                S_COPYW:
                begin
                    if (!bmp_rd_reg)
                        cnt_reg <= cnt_reg + 1'b1;
                    j_reg <= j_reg + 1'b1;
                    if (copy_last)
                        st_reg <= S_IDLE;
                    else
                        st_reg <= S_COPY;
                end
                S_TRD:
                begin
                    if (tab_end)
                        st_reg <= S_IDLE;
                    else
                        st_reg <= S_TSQ;
                end
                S_TSQ:
                begin
                    sq_reg <= (2*PW)'(tab_rd_reg) * (2*PW)'(tab_rd_reg);
                    st_reg <= S_TCMP;
                end
                S_TCMP:
                begin
                    if (sq_over)
                        st_reg <= S_IDLE;
                    else
                        st_reg <= S_TDIV;
                end
                S_TDIV:  st_reg <= S_TREM;
                S_TREM:
                begin
                    if (div_hit)
                    begin
                        prime_reg <= 1'b0;
                        st_reg    <= S_IDLE;
                    end
                    else if (div_done)
                    begin
                        idx_reg <= idx_reg + 1'b1;
                        st_reg  <= S_TAB;
                    end
                end
                S_TAB:   st_reg <= S_TRD;
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            n_reg <= number_in;
    end

    assign number_out = n_reg;
    assign is_prime   = prime_reg;
endmodule
`default_nettype wire

>>> design/tdpt_ctrl.sv
// ----------------------------------------------------------------------------
// tdpt_ctrl
// Sequences start-up sieve, input acceptance and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none
module tdpt_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic                in_last,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic                     out_last,
    output tdpt_pkg::tdpt_cmd_t      cmd,
    input  wire tdpt_pkg::tdpt_sts_t sts
);
    import tdpt_pkg::*;

    localparam logic [2:0] C_BOOT = 3'd0;
    localparam logic [2:0] C_CLR  = 3'd1;
    localparam logic [2:0] C_SIV  = 3'd2;
    localparam logic [2:0] C_IDLE = 3'd3;
    localparam logic [2:0] C_KICK = 3'd4;
    localparam logic [2:0] C_TEST = 3'd5;
    localparam logic [2:0] C_OUT  = 3'd6;

    logic [2:0] st_reg;
    logic [2:0] st_next;
    logic       last_reg;

    assign in_ready  = (st_reg == C_IDLE);
    assign out_valid = (st_reg == C_OUT);
    assign out_last  = last_reg;

    always_comb
    begin
        st_next = st_reg;
        cmd     = '0;
        case (st_reg)
            C_BOOT:
            begin
                cmd.clr_start = 1'b1;
                st_next       = C_CLR;
            end
            C_CLR:
            begin
                if (sts.clr_done)
                begin
                    cmd.siv_start = 1'b1;
                    st_next       = C_SIV;
                end
            end
            C_SIV:  if (sts.siv_done) st_next = C_IDLE;
            C_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    st_next  = C_KICK;
                end
            end
            C_KICK:
            begin
                cmd.tst_start = 1'b1;
                st_next       = C_TEST;
            end
            C_TEST: if (sts.tst_done) st_next = C_OUT;
            C_OUT:  if (out_ready) st_next = C_IDLE;
            default: st_next = C_BOOT;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= C_BOOT;
            last_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (st_reg == C_IDLE && in_valid)
                last_reg <= in_last;
        end
    end
endmodule
`default_nettype wire

>>> design/trial_division_prime_test.sv
// ----------------------------------------------------------------------------
// trial_division_prime_test
// Primality tester: start-up sieve, then trial division by stored primes.
// ----------------------------------------------------------------------------
// After reset the block clears its bitmap, sieves it and copies the primes
// into a table; s_axis_tready stays low meanwhile. Each number is then
// divided by the stored primes p with p*p <= number in the bit-serial
// remainder unit; one number is in work at a time.
// ----------------------------------------------------------------------------
`default_nettype none
module trial_division_prime_test #(
    parameter int SIEVE_LIMIT  = 65536,
    parameter int TABLE_DEPTH  = 8192,
    parameter int NUMBER_WIDTH = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // number
    input  wire logic        s_axis_tlast,   // last_in_range
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // tested_number
    output logic             m_axis_tuser,   // is_prime
    output logic             m_axis_tlast    // last_in_range_res
);
    import tdpt_pkg::*;

    tdpt_cmd_t                cmd;
    tdpt_sts_t                sts;
    logic [NUMBER_WIDTH-1:0]  num_in;
    logic [NUMBER_WIDTH-1:0]  num_out;

    assign num_in = NUMBER_WIDTH'(s_axis_tdata);

    tdpt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_last   (s_axis_tlast),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_last  (m_axis_tlast),
        .cmd       (cmd),
        .sts       (sts)
    );

    tdpt_datapath #(
        .SIEVE_LIMIT  (SIEVE_LIMIT),
        .TABLE_DEPTH  (TABLE_DEPTH),
        .NUMBER_WIDTH (NUMBER_WIDTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .number_in  (num_in),
        .number_out (num_out),
        .is_prime   (m_axis_tuser)
    );

    assign m_axis_tdata = 32'(num_out);
endmodule
`default_nettype wire
